/* src/page_frame_lru_replacer_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the page frame LRU replacer
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_LRU_REPLACER_UNIT_MACROS_SVH
`define PAGE_FRAME_LRU_REPLACER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// prop is a full property expression (may use |-> or |=>)
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* src/pflru_pkg.sv */
// ---------------------------------------------------------------------------
// pflru_pkg
// Shared widths, opcodes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package pflru_pkg;

	localparam int OP_W    = 3;
	localparam int PAGE_W  = 16;
	localparam int PID_W   = 16;
	localparam int SLOT_W  = 4;
	localparam int FIDX_W  = 4;
	localparam int STAMP_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_FETCH    = 3'd0,
		OP_ADD      = 3'd1,
		OP_PLACE    = 3'd2,
		OP_KILL     = 3'd3,
		OP_DESELECT = 3'd4,
		OP_REFRESH  = 3'd5
	} opcode_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture transaction, clear scan state
		logic rd;        // read frame at scan index
		logic eval;      // evaluate frame read last cycle
		logic inc_idx;   // advance scan index
		logic install;   // write page into victim or slot frame
		logic stamp_wr;  // refresh running frame's stamp
		logic deselect;  // clear all running marks
		logic post;      // load output register
	} pflru_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    hit;        // lookup match on the frame under evaluation
		logic    last;       // scan index is at the last frame
		logic    cur_found;  // a running frame was seen during refresh scan
		logic    slot_ok;    // place target is an existing frame
	} pflru_sts_t;

endpackage

/* src/pflru_dp.sv */
// ---------------------------------------------------------------------------
// pflru_dp
// Frame table storage, scan evaluation, victim tracking and output register.
// ---------------------------------------------------------------------------
`include "page_frame_lru_replacer_unit_macros.svh"

module pflru_dp
	import pflru_pkg::*;
#(
	parameter int FRAMES = 16,
	localparam int IW = $clog2(FRAMES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [OP_W-1:0]     in_opcode,
	input  logic [PAGE_W-1:0]   in_page,
	input  logic [PID_W-1:0]    in_pid,
	input  logic                in_run,
	input  logic [SLOT_W-1:0]   in_slot,
	input  pflru_cmd_t          cmd,
	output pflru_sts_t          sts,
	output logic [FIDX_W-1:0]   frame_index,
	output logic                hit
);

	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] v);
		return (v == STAMP_MAX) ? v : v + STAMP_W'(1);
	endfunction

	// Captured transaction
	opcode_t             op_q;
	logic [PAGE_W-1:0]   page_q;
	logic [PID_W-1:0]    pid_q;
	logic                run_q;
	logic [SLOT_W-1:0]   slot_q;

	// Frame storage: memories plus per-frame valid bits and running marks
	logic [PAGE_W-1:0]   page_mem  [FRAMES];
	logic [PID_W-1:0]    owner_mem [FRAMES];
	logic [STAMP_W-1:0]  stamp_mem [FRAMES];
	logic [FRAMES-1:0]   vpo_q;
	logic [FRAMES-1:0]   vst_q;
	logic [FRAMES-1:0]   running_q;

	// Registered read data
	logic [PAGE_W-1:0]   rd_page_q;
	logic [PID_W-1:0]    rd_owner_q;
	logic [STAMP_W-1:0]  rd_stamp_q;
	logic                rd_vpo_q;
	logic                rd_vst_q;
	logic                rd_run_q;

	// Scan state
	logic [IW-1:0]       idx_q;
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic [IW-1:0]       best_idx_q;
	logic [STAMP_W-1:0]  best_stamp_q;
	logic [STAMP_W-1:0]  top_q;
	logic                cur_found_q;
	logic [IW-1:0]       cur_idx_q;
	logic [STAMP_W-1:0]  ctr_q;
	logic [IW-1:0]       res_idx_q;
	logic                res_hit_q;
	logic [FIDX_W-1:0]   frame_index_q;
	logic                hit_q;

	logic [PAGE_W-1:0]   e_page;
	logic [PID_W-1:0]    e_owner;
	logic [STAMP_W-1:0]  e_stamp;
	logic                match;
	logic                lookup_mode;
	logic                vrun;
	logic                slot_ok;
	logic [IW-1:0]       victim;
	logic [IW-1:0]       target;
	logic [STAMP_W-1:0]  ctr_inc;

	// Entries without a valid bit read as zero
	assign e_page  = rd_vpo_q ? rd_page_q  : '0;
	assign e_owner = rd_vpo_q ? rd_owner_q : '0;
	assign e_stamp = rd_vst_q ? rd_stamp_q : '0;

	assign match       = (e_page == page_q) && (e_owner == pid_q);
	assign lookup_mode = (op_q == OP_FETCH) || ((op_q == OP_ADD) && run_q);
	// after a lookup miss every scanned mark is gone
	assign vrun        = lookup_mode ? 1'b0 : rd_run_q;
	assign slot_ok     = (32'(slot_q) < 32'(FRAMES));
	assign victim      = free_found_q ? free_idx_q : best_idx_q;
	assign target      = (op_q == OP_PLACE) ? IW'(slot_q) : victim;
	assign ctr_inc     = sat_inc(ctr_q);

	assign sts.op        = op_q;
	assign sts.hit       = lookup_mode && match;
	assign sts.last      = (idx_q == IW'(FRAMES - 1));
	assign sts.cur_found = cur_found_q;
	assign sts.slot_ok   = slot_ok;

	assign frame_index = frame_index_q;
	assign hit         = hit_q;

	// Transaction capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode_t'(in_opcode);
			page_q <= in_page;
			pid_q  <= in_pid;
			run_q  <= in_run;
			slot_q <= in_slot;
		end
	end

	// Memory read port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_page_q  <= page_mem[idx_q];
			rd_owner_q <= owner_mem[idx_q];
			rd_stamp_q <= stamp_mem[idx_q];
			rd_vpo_q   <= vpo_q[idx_q];
			rd_vst_q   <= vst_q[idx_q];
			rd_run_q   <= running_q[idx_q];
		end
	end

	// Memory write port
	always_ff @(posedge clk) begin
		if (cmd.install) begin
			page_mem[target]  <= page_q;
			owner_mem[target] <= pid_q;
			stamp_mem[target] <= ctr_inc;
		end else if (cmd.stamp_wr) begin
			stamp_mem[cur_idx_q] <= sat_inc(top_q);
		end
	end

	// Scan evaluation, flags, counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpo_q         <= '0;
			vst_q         <= '0;
			running_q     <= '0;
			idx_q         <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			best_idx_q    <= '0;
			best_stamp_q  <= '0;
			top_q         <= '0;
			cur_found_q   <= 1'b0;
			cur_idx_q     <= '0;
			ctr_q         <= '0;
			res_idx_q     <= '0;
			res_hit_q     <= 1'b0;
			frame_index_q <= '0;
			hit_q         <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				cur_found_q  <= 1'b0;
				top_q        <= '0;
				res_idx_q    <= '0;
				res_hit_q    <= 1'b0;
			end
			if (cmd.deselect) begin
				running_q <= '0;
			end
			if (cmd.eval) begin
				case (op_q)
					OP_FETCH, OP_ADD: begin
						if (lookup_mode) begin
							if (match) begin
								if (op_q == OP_ADD) begin
									running_q[idx_q] <= 1'b1;
								end
								res_idx_q <= idx_q;
								res_hit_q <= 1'b1;
							end else begin
								running_q[idx_q] <= 1'b0;
							end
						end
						// first free frame wins
						if (!free_found_q && (e_owner == '0)) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q;
						end
						// oldest not-running stamp, frame 0 as the start
						if (idx_q == '0) begin
							best_idx_q   <= '0;
							best_stamp_q <= e_stamp;
						end else if (!vrun && (e_stamp < best_stamp_q)) begin
							best_idx_q   <= idx_q;
							best_stamp_q <= e_stamp;
						end
					end
					OP_KILL: begin
						if (e_owner == pid_q) begin
							vpo_q[idx_q]     <= 1'b0;
							vst_q[idx_q]     <= 1'b0;
							running_q[idx_q] <= 1'b0;
						end
					end
					OP_REFRESH: begin
						if (e_stamp > top_q) begin
							top_q <= e_stamp;
						end
						if (rd_run_q) begin
							cur_found_q <= 1'b1;
							cur_idx_q   <= idx_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.inc_idx) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.install) begin
				ctr_q             <= ctr_inc;
				vpo_q[target]     <= 1'b1;
				vst_q[target]     <= 1'b1;
				// a fetch always installs its page as the running one
				running_q[target] <= (op_q == OP_FETCH) ? 1'b1 : run_q;
				res_idx_q         <= target;
			end
			if (cmd.stamp_wr) begin
				ctr_q            <= ctr_inc;
				vst_q[cur_idx_q] <= 1'b1;
			end
			if (cmd.post) begin
				frame_index_q <= FIDX_W'(res_idx_q);
				hit_q         <= res_hit_q;
			end
		end
	end

	`ASSERT_IMPL(a_ctr_mono, clk, arst_n, 1'b1 |=> (ctr_q >= $past(ctr_q)), "use counter went backward")
	`ASSERT_NEVER(a_idx_range, clk, arst_n, (32'(idx_q) > (FRAMES - 1)), "scan index out of range")
	`ASSERT_IMPL(a_out_hold, clk, arst_n, !cmd.post |=> $stable(frame_index_q), "output changed without post")

endmodule

/* src/pflru_ctrl.sv */
// ---------------------------------------------------------------------------
// pflru_ctrl
// Sequencer: accepts a transaction, walks the frame scan, issues writes and
// hands the result to the output register.
// ---------------------------------------------------------------------------
`include "page_frame_lru_replacer_unit_macros.svh"

module pflru_ctrl
	import pflru_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  in_opcode,
	output logic             out_valid,
	input  logic             out_ready,
	input  pflru_sts_t       sts,
	output pflru_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_WR,
		ST_REFW,
		ST_DONE
	} state_t;

	state_t  state_q;
	logic    out_valid_q;
	logic    accept;
	opcode_t in_op;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_op     = opcode_t'(in_opcode);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load     = accept;
				cmd.deselect = accept && (in_op == OP_DESELECT);
			end
			ST_RD: begin
				cmd.rd = 1'b1;
			end
			ST_EV: begin
				cmd.eval    = 1'b1;
				cmd.inc_idx = !sts.hit && !sts.last;
			end
			ST_WR: begin
				cmd.install = (sts.op != OP_PLACE) || sts.slot_ok;
			end
			ST_REFW: begin
				cmd.stamp_wr = sts.cur_found;
			end
			ST_DONE: begin
				cmd.post = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_FETCH, OP_ADD, OP_KILL, OP_REFRESH: state_q <= ST_RD;
							OP_PLACE: state_q <= ST_WR;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (sts.hit) begin
						state_q <= ST_DONE;
					end else if (sts.last) begin
						case (sts.op)
							OP_KILL:    state_q <= ST_DONE;
							OP_REFRESH: state_q <= ST_REFW;
							default:    state_q <= ST_WR;
						endcase
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_WR: begin
					state_q <= ST_DONE;
				end
				ST_REFW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.post) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_post_valid, clk, arst_n, cmd.post |=> out_valid_q, "posted result not valid")
	`ASSERT_IMPL(a_hit_done, clk, arst_n, ((state_q == ST_EV) && sts.hit) |=> (state_q == ST_DONE), "hit did not end scan")
	`ASSERT_NEVER(a_wr_scan, clk, arst_n, ((cmd.install || cmd.stamp_wr) && (cmd.rd || cmd.eval)), "write during scan")

endmodule

/* src/page_frame_lru_replacer_unit.sv */
// ---------------------------------------------------------------------------
// page_frame_lru_replacer_unit
// Frame table with LRU-style replacement for (page, process) pairs.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one transaction of
// opcode, page_number, process_id, running_flag and frame_slot. Each one
// produces exactly one transaction on the output channel (out_valid/
// out_ready) with frame_index and hit.
// Fetch, and add with running flag, scan the frames and stop at a hit;
// add without running flag, kill and refresh scan every frame; place
// skips the scan; deselect and unused opcodes go straight to the result.
// The frame scan reads one frame at a time (memory read, then
// evaluate) through a single read port; that loop sets the rate.
// One transaction is in work at a time; in_ready is high whenever the
// sequencer is idle, even while a finished result waits in the output
// register. If the receiver stalls, the next result waits until the
// output register frees.
// Reset clears all frames to free, all marks and stamps to zero and the use
// counter to zero at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module page_frame_lru_replacer_unit
	import pflru_pkg::*;
#(
	parameter int FRAMES = 16   // 2 to 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [PAGE_W-1:0]  page_number,
	input  logic [PID_W-1:0]   process_id,
	input  logic               running_flag,
	input  logic [SLOT_W-1:0]  frame_slot,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIDX_W-1:0]  frame_index,
	output logic               hit
);

	pflru_cmd_t cmd;
	pflru_sts_t sts;

	pflru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pflru_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_opcode   (opcode),
		.in_page     (page_number),
		.in_pid      (process_id),
		.in_run      (running_flag),
		.in_slot     (frame_slot),
		.cmd         (cmd),
		.sts         (sts),
		.frame_index (frame_index),
		.hit         (hit)
	);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: page frame LRU replacer bench
// Directed and random frame table transactions go to the unit. A local copy of
// the frame table predicts frame_index and hit for every accepted transaction,
// and each returned transaction is checked in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import pflru_pkg::*;

	localparam int FRAMES     = 16;
	localparam int HALF_CYC   = 4;
	localparam int STALL_PCT  = 28;
	localparam int RAND_ITEMS = 600;
	localparam int DRAIN_GAP  = 150;
	localparam int WDOG_LIMIT = 4000;
	localparam int TAIL_CYC   = 50;

	// opcodes the unit must ignore
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PAGE_W-1:0] page;
		logic [PID_W-1:0]  pid;
		logic              run;
		logic [SLOT_W-1:0] slot;
		bit                drain_first;   // hold until every result is back
	} frame_cmd_t;

	typedef struct packed {
		logic [FIDX_W-1:0] fidx;
		logic              hit;
	} frame_res_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [OP_W-1:0]    opcode       = '0;
	logic [PAGE_W-1:0]  page_number  = '0;
	logic [PID_W-1:0]   process_id   = '0;
	logic               running_flag = 1'b0;
	logic [SLOT_W-1:0]  frame_slot   = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [FIDX_W-1:0]  frame_index;
	logic               hit;

	page_frame_lru_replacer_unit #(.FRAMES(FRAMES)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.page_number  (page_number),
		.process_id   (process_id),
		.running_flag (running_flag),
		.frame_slot   (frame_slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_index  (frame_index),
		.hit          (hit)
	);

	always #HALF_CYC clk = ~clk;

	// bench copy of the frame table
	logic [PAGE_W-1:0]  pg_tbl    [FRAMES];
	logic [PID_W-1:0]   own_tbl   [FRAMES];
	logic               run_tbl   [FRAMES];
	logic [STAMP_W-1:0] stamp_tbl [FRAMES];
	logic [STAMP_W-1:0] use_cnt;

	frame_cmd_t cmd_q[$];
	frame_res_t frame_res_q[$];
	frame_cmd_t drv_cmd;
	frame_res_t want;
	int         cmd_total  = 0;
	int         live_cnt   = 0;   // queued transactions the unit acts on
	int         drain_mark = 0;
	int         sent_cnt   = 0;
	int         err_cnt    = 0;
	int         quiet_cyc  = 0;
	logic       req_taken  = 1'b0;
	logic       calm;

	// no idling on either side over one long stretch
	assign calm = (sent_cnt >= 250) && (sent_cnt < 400);

	function automatic logic [STAMP_W-1:0] sat_bump(input logic [STAMP_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// lookup; frames passed over lose their running mark, all of them on a miss
	function automatic int find_pair(input logic [PAGE_W-1:0] pg,
			input logic [PID_W-1:0] pid);
		for (int i = 0; i < FRAMES; i++) begin
			if (pg_tbl[i] == pg && own_tbl[i] == pid)
				return i;
			run_tbl[i] = 1'b0;
		end
		return -1;
	endfunction

	// first free frame, else oldest stamp among frames not running
	function automatic int pick_victim();
		int best;
		best = 0;
		for (int i = 0; i < FRAMES; i++) begin
			if (own_tbl[i] == '0)
				return i;
			if (!run_tbl[i] && stamp_tbl[i] < stamp_tbl[best])
				best = i;
		end
		return best;
	endfunction

	task automatic load_frame(input int f, input logic [PAGE_W-1:0] pg,
			input logic [PID_W-1:0] pid, input logic run);
		use_cnt      = sat_bump(use_cnt);
		pg_tbl[f]    = pg;
		own_tbl[f]   = pid;
		run_tbl[f]   = run;
		stamp_tbl[f] = use_cnt;
	endtask

	// apply one transaction to the table and queue the result it yields
	task automatic replace_step(input frame_cmd_t c);
		int                 f;
		int                 cur;
		logic [STAMP_W-1:0] top;
		frame_res_t         r;
		r = '0;
		case (c.op)
			OP_FETCH: begin
				f = find_pair(c.page, c.pid);
				if (f >= 0) begin
					r.hit = 1'b1;
				end else begin
					f = pick_victim();
					load_frame(f, c.page, c.pid, 1'b1);
				end
				r.fidx = FIDX_W'(f);
			end
			OP_ADD: begin
				f = -1;
				if (c.run) begin
					f = find_pair(c.page, c.pid);
					if (f >= 0) begin
						run_tbl[f] = 1'b1;
						r.hit      = 1'b1;
					end
				end
				if (f < 0) begin
					f = pick_victim();
					load_frame(f, c.page, c.pid, c.run);
				end
				r.fidx = FIDX_W'(f);
			end
			OP_PLACE: begin
				if (int'(c.slot) < FRAMES) begin
					load_frame(int'(c.slot), c.page, c.pid, c.run);
					r.fidx = c.slot;
				end
			end
			OP_KILL: begin
				for (int i = 0; i < FRAMES; i++) begin
					if (own_tbl[i] == c.pid) begin
						pg_tbl[i]    = '0;
						own_tbl[i]   = '0;
						run_tbl[i]   = 1'b0;
						stamp_tbl[i] = '0;
					end
				end
			end
			OP_DESELECT: begin
				for (int i = 0; i < FRAMES; i++)
					run_tbl[i] = 1'b0;
			end
			OP_REFRESH: begin
				top = '0;
				cur = -1;
				for (int i = 0; i < FRAMES; i++) begin
					if (stamp_tbl[i] > top)
						top = stamp_tbl[i];
					if (run_tbl[i])
						cur = i;
				end
				if (cur >= 0) begin
					stamp_tbl[cur] = sat_bump(top);
					use_cnt        = sat_bump(use_cnt);
				end
			end
			default: begin
			end
		endcase
		frame_res_q = {frame_res_q, r};
	endtask

	task automatic report_bad(input string what);
		err_cnt++;
		if (err_cnt <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic push_cmd(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
			input logic [PID_W-1:0] pid, input logic run, input logic [SLOT_W-1:0] slot);
		frame_cmd_t c;
		c.op          = op;
		c.page        = pg;
		c.pid         = pid;
		c.run         = run;
		c.slot        = slot;
		c.drain_first = (cmd_total >= drain_mark);
		if (c.drain_first)
			drain_mark += DRAIN_GAP;
		cmd_q = {cmd_q, c};
		cmd_total++;
		if (op <= OP_REFRESH)
			live_cnt++;
	endtask

	// mostly a small pool so that pairs repeat and hit
	function automatic logic [PAGE_W-1:0] rand_page();
		if ($urandom_range(0, 99) < 80)
			return PAGE_W'($urandom_range(0, 7));
		return PAGE_W'($urandom);
	endfunction

	function automatic logic [PID_W-1:0] rand_pid();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return PID_W'($urandom_range(1, 5));
		if (roll < 90)
			return '0;
		return PID_W'($urandom);
	endfunction

	function automatic logic [OP_W-1:0] rand_ws_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return OP_FETCH;
		if (roll < 65) return OP_ADD;
		if (roll < 75) return OP_PLACE;
		if (roll < 88) return OP_REFRESH;
		if (roll < 95) return OP_DESELECT;
		return OP_KILL;
	endfunction

	// stimulus, reset and end of run
	initial begin
		int n;
		int roll;
		drain_mark = 19;

		// directed: special cases and field extremes
		push_cmd(OP_REFRESH,  16'h0000, 16'h0000, 1'b0, 4'd0);  // nothing running
		push_cmd(OP_FETCH,    16'h0000, 16'h0000, 1'b0, 4'd0);  // (0,0) hits free frame
		push_cmd(OP_FETCH,    16'h0001, 16'h0001, 1'b0, 4'd0);
		push_cmd(OP_FETCH,    16'hFFFF, 16'hFFFF, 1'b1, 4'd0);
		push_cmd(OP_FETCH,    16'h0001, 16'h0001, 1'b0, 4'd0);  // hit keeps mark
		push_cmd(OP_ADD,      16'hFFFF, 16'hFFFF, 1'b1, 4'd0);  // hit becomes running
		push_cmd(OP_ADD,      16'h0001, 16'h0001, 1'b0, 4'd0);  // install, no lookup
		push_cmd(OP_PLACE,    16'hA5A5, 16'h5A5A, 1'b1, 4'd15);
		push_cmd(OP_PLACE,    16'h1234, 16'h0002, 1'b0, 4'd0);
		push_cmd(OP_REFRESH,  16'h0000, 16'h0000, 1'b0, 4'd0);
		push_cmd(OP_DESELECT, 16'hFFFF, 16'hFFFF, 1'b1, 4'd15);
		push_cmd(OP_REFRESH,  16'h0000, 16'h0000, 1'b0, 4'd0);  // no running frame
		push_cmd(OP_SPARE6,   16'hFFFF, 16'hFFFF, 1'b1, 4'd15);
		push_cmd(OP_SPARE7,   16'h0000, 16'h0000, 1'b0, 4'd0);
		push_cmd(OP_KILL,     16'h0000, 16'hFFFF, 1'b0, 4'd0);
		push_cmd(OP_KILL,     16'h0000, 16'h0001, 1'b0, 4'd0);
		push_cmd(OP_FETCH,    16'h0000, 16'h0000, 1'b0, 4'd0);
		push_cmd(OP_ADD,      16'h0007, 16'h0003, 1'b1, 4'd0);
		push_cmd(OP_PLACE,    16'h0000, 16'h0000, 1'b1, 4'd0);  // frame 0 made free
		push_cmd(OP_FETCH,    16'h0005, 16'h0004, 1'b0, 4'd0);

		// random bursts of well-formed work plus some noise
		while (live_cnt < RAND_ITEMS + 20) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				// fill the whole table, then force victim choice by age
				for (int s = 0; s < FRAMES; s++)
					push_cmd(OP_PLACE, rand_page(), PID_W'($urandom_range(1, 5)),
						1'($urandom_range(0, 1)), SLOT_W'(s));
				n = $urandom_range(2, 5);
				for (int k = 0; k < n; k++)
					push_cmd(($urandom_range(0, 1) != 0) ? OP_FETCH : OP_ADD,
						PAGE_W'($urandom_range(8, 40)), PID_W'($urandom_range(1, 5)),
						1'($urandom_range(0, 1)), '0);
			end else if (roll < 80) begin
				n = $urandom_range(6, 20);
				for (int k = 0; k < n; k++)
					push_cmd(rand_ws_op(), rand_page(), rand_pid(),
						1'($urandom_range(0, 1)), SLOT_W'($urandom));
			end else if (roll < 90) begin
				push_cmd(OP_KILL, rand_page(), rand_pid(), 1'($urandom_range(0, 1)),
					SLOT_W'($urandom));
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					push_cmd(OP_FETCH, rand_page(), rand_pid(), 1'b0, '0);
			end else begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					push_cmd(OP_W'($urandom_range(0, 7)), PAGE_W'($urandom),
						PID_W'($urandom), 1'($urandom_range(0, 1)), SLOT_W'($urandom));
			end
		end

		// table copy matches the reset state
		for (int i = 0; i < FRAMES; i++) begin
			pg_tbl[i]    = '0;
			own_tbl[i]   = '0;
			run_tbl[i]   = 1'b0;
			stamp_tbl[i] = '0;
		end
		use_cnt = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_cnt != cmd_total || frame_res_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYC) @(negedge clk);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// request driver: next transaction or an idle cycle, changed on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (cmd_q.size() != 0
					&& !(cmd_q[0].drain_first && frame_res_q.size() != 0)
					&& (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
				drv_cmd = cmd_q.pop_front();
				in_valid     <= 1'b1;
				opcode       <= drv_cmd.op;
				page_number  <= drv_cmd.page;
				process_id   <= drv_cmd.pid;
				running_flag <= drv_cmd.run;
				frame_slot   <= drv_cmd.slot;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// monitor: check results, predict accepted requests, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (frame_res_q.size() == 0) begin
					report_bad($sformatf("unexpected result frame_index %0d hit %0b",
						frame_index, hit));
				end else begin
					want = frame_res_q.pop_front();
					if (frame_index !== want.fidx)
						report_bad($sformatf("frame_index expected %0d got %0d",
							want.fidx, frame_index));
					if (hit !== want.hit)
						report_bad($sformatf("hit expected %0b got %0b", want.hit, hit));
				end
			end
			if (in_valid && in_ready) begin
				replace_step('{op: opcode, page: page_number, pid: process_id,
					run: running_flag, slot: frame_slot, drain_first: 1'b0});
				sent_cnt++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= WDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

/* filelist.f */
+incdir+src
src/pflru_pkg.sv
src/pflru_dp.sv
src/pflru_ctrl.sv
src/page_frame_lru_replacer_unit.sv
bench/tb_top.sv
